### rtl/fiws_pkg.sv
// Shared widths and the divider status type for the frame interval statistics block.
`timescale 1ns / 1ps
`default_nettype none
package fiws_pkg;

  localparam int unsigned TsW      = 48;
  localparam int unsigned IvlW     = 32;
  localparam int unsigned CntW     = 32;
  localparam int unsigned FillOutW = 9;

  localparam logic OpFrame   = 1'b0;
  localparam logic OpRestart = 1'b1;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage
`default_nettype wire

### rtl/frame_interval_window_stats.sv
// Top level of the frame interval statistics block with its window memory and sequencer.
`timescale 1ns / 1ps
`default_nettype none
// Each request carries a 48-bit microsecond timestamp and a frame or restart opcode, and it
// yields one result: the interval since the previous frame, the time since restart, the mean
// and maximum of the last WINDOW_DEPTH nonzero intervals, the frame count and the window fill.
// A restart, or the first frame after reset, reports all zeros. A new request is accepted
// only once the previous one is through. The idle state accepts the request and the evaluate
// state evaluates it. For a frame the window memory is then read one entry per cycle, and the
// registered read drains, to form the sum and maximum. The mean comes from a serial divider
// that produces one quotient bit per cycle, 41 bits at the default depth, and then raises its
// done flag. The finish state loads the result. A restart skips the scan and the divide, and
// a frame over an empty window skips the divide. A finished result waits in the output
// register while the next request is accepted. While the receiver stalls and the output
// register is full, the next result waits and no further request is accepted.
module frame_interval_window_stats
  import fiws_pkg::*;
#(
  parameter int unsigned WINDOW_DEPTH = 256
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output      logic                in_stall_o,
  input  wire logic                opcode_i,
  input  wire logic [TsW-1:0]      timestamp_us_i,
  output      logic                out_valid_o,
  input  wire logic                out_stall_i,
  output      logic [IvlW-1:0]     interval_us_o,
  output      logic [TsW-1:0]      elapsed_us_o,
  output      logic [IvlW-1:0]     window_average_us_o,
  output      logic [IvlW-1:0]     window_maximum_us_o,
  output      logic [CntW-1:0]     frame_count_o,
  output      logic [FillOutW-1:0] window_fill_o
);

  localparam int unsigned PtrW  = $clog2(WINDOW_DEPTH);
  localparam int unsigned FillW = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned SumW  = IvlW + FillW;

  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StEval   = 3'd1;
  localparam logic [2:0] StScan   = 3'd2;
  localparam logic [2:0] StDiv    = 3'd3;
  localparam logic [2:0] StFinish = 3'd4;

  logic [2:0]       state_q, state_d;
  logic             running_q, running_d;
  logic [TsW-1:0]   start_q, start_d;
  logic [TsW-1:0]   last_q, last_d;
  logic [PtrW-1:0]  wp_q, wp_d;
  logic [FillW-1:0] fill_q, fill_d;
  logic [CntW-1:0]  frames_q, frames_d;
  logic             op_q, op_d;
  logic [TsW-1:0]   ts_q, ts_d;
  logic [IvlW-1:0]  ivl_q, ivl_d;
  logic [TsW-1:0]   elapsed_q, elapsed_d;
  logic [SumW-1:0]  sum_q, sum_d;
  logic [IvlW-1:0]  max_q, max_d;
  logic [IvlW-1:0]  avg_q, avg_d;
  logic [FillW-1:0] scan_q, scan_d;
  logic             rd_vld_q, rd_vld_d;

  logic             out_valid_q, out_valid_d;
  logic [IvlW-1:0]  out_ivl_q, out_elapsed_unused_dummy;
  logic [TsW-1:0]   out_elapsed_q;
  logic [IvlW-1:0]  out_avg_q;
  logic [IvlW-1:0]  out_max_q;
  logic [CntW-1:0]  out_frames_q;
  logic [FillW-1:0] out_fill_q;
  logic             out_load;

  logic [IvlW-1:0]  ring_q [WINDOW_DEPTH];
  logic [IvlW-1:0]  rd_data_q;
  logic             ring_we;
  logic [PtrW-1:0]  rd_addr;

  logic [TsW-1:0]   diff;
  logic [IvlW-1:0]  ivl_sat;

  logic             div_start;
  div_stat_t        div_stat;
  logic [SumW-1:0]  div_quo;

  assign out_elapsed_unused_dummy = '0;

  fiws_divider #(
    .DividendW(SumW),
    .DivisorW (FillW)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(sum_q),
    .divisor_i (fill_q),
    .stat_o    (div_stat),
    .quotient_o(div_quo)
  );

  assign diff    = ts_q - last_q;
  assign ivl_sat = (diff[TsW-1:IvlW] != '0) ? '1 : diff[IvlW-1:0];
  assign rd_addr = scan_q[PtrW-1:0];

  always_comb begin
    state_d     = state_q;
    running_d   = running_q;
    start_d     = start_q;
    last_d      = last_q;
    wp_d        = wp_q;
    fill_d      = fill_q;
    frames_d    = frames_q;
    op_d        = op_q;
    ts_d        = ts_q;
    ivl_d       = ivl_q;
    elapsed_d   = elapsed_q;
    sum_d       = sum_q;
    max_d       = max_q;
    avg_d       = avg_q;
    scan_d      = scan_q;
    rd_vld_d    = 1'b0;
    ring_we     = 1'b0;
    div_start   = 1'b0;
    out_load    = 1'b0;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          op_d    = opcode_i;
          ts_d    = timestamp_us_i;
          state_d = StEval;
        end
      end
      StEval: begin
        if (op_q == OpRestart || !running_q) begin
          running_d = 1'b1;
          start_d   = ts_q;
          last_d    = ts_q;
          wp_d      = '0;
          fill_d    = '0;
          frames_d  = '0;
          ivl_d     = '0;
          elapsed_d = '0;
          avg_d     = '0;
          max_d     = '0;
          state_d   = StFinish;
        end else begin
          ivl_d     = ivl_sat;
          elapsed_d = ts_q - start_q;
          last_d    = ts_q;
          frames_d  = frames_q + CntW'(1);
          if (ivl_sat != '0) begin
            ring_we = 1'b1;
            wp_d    = (wp_q == PtrW'(WINDOW_DEPTH - 1)) ? '0 : wp_q + PtrW'(1);
            if (fill_q < FillW'(WINDOW_DEPTH)) begin
              fill_d = fill_q + FillW'(1);
            end
          end
          sum_d   = '0;
          max_d   = '0;
          scan_d  = '0;
          state_d = StScan;
        end
      end
      StScan: begin
        if (scan_q < fill_q) begin
          rd_vld_d = 1'b1;
          scan_d   = scan_q + FillW'(1);
        end
        if (rd_vld_q) begin
          sum_d = sum_q + SumW'(rd_data_q);
          if (rd_data_q > max_q) begin
            max_d = rd_data_q;
          end
        end
        if (scan_q == fill_q && !rd_vld_q) begin
          if (fill_q == '0) begin
            avg_d   = '0;
            state_d = StFinish;
          end else begin
            div_start = 1'b1;
            state_d   = StDiv;
          end
        end
      end
      StDiv: begin
        if (div_stat.done) begin
          avg_d   = div_quo[IvlW-1:0];
          state_d = StFinish;
        end
      end
      StFinish: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      running_q   <= 1'b0;
      start_q     <= '0;
      last_q      <= '0;
      wp_q        <= '0;
      fill_q      <= '0;
      frames_q    <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      running_q   <= running_d;
      start_q     <= start_d;
      last_q      <= last_d;
      wp_q        <= wp_d;
      fill_q      <= fill_d;
      frames_q    <= frames_d;
      rd_vld_q    <= rd_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    ts_q      <= ts_d;
    ivl_q     <= ivl_d;
    elapsed_q <= elapsed_d;
    sum_q     <= sum_d;
    max_q     <= max_d;
    avg_q     <= avg_d;
    scan_q    <= scan_d;
    if (out_load) begin
      out_ivl_q     <= ivl_q;
      out_elapsed_q <= elapsed_q;
      out_avg_q     <= avg_q;
      out_max_q     <= max_q;
      out_frames_q  <= frames_q;
      out_fill_q    <= fill_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring_q[wp_q] <= ivl_sat;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= ring_q[rd_addr];
  end

  assign in_stall_o          = (state_q != StIdle);
  assign out_valid_o         = out_valid_q;
  assign interval_us_o       = out_ivl_q | out_elapsed_unused_dummy;
  assign elapsed_us_o        = out_elapsed_q;
  assign window_average_us_o = out_avg_q;
  assign window_maximum_us_o = out_max_q;
  assign frame_count_o       = out_frames_q;
  assign window_fill_o       = FillOutW'(out_fill_q);

  // The window never holds more intervals than it has entries.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillW'(WINDOW_DEPTH))
    else $error("window fill exceeds depth");

  // A mean over the stored intervals can never exceed their maximum.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (window_average_us_o <= window_maximum_us_o))
    else $error("window average above window maximum");

  // The divider runs only while the sequencer waits for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.busy |-> (state_q == StDiv))
    else $error("divider busy outside the divide step");

  // A divide starts only after the scan has covered a nonempty window.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> (fill_q != '0 && scan_q == fill_q))
    else $error("divide started before the scan finished");

endmodule
`default_nettype wire

### rtl/fiws_divider.sv
// Restoring serial divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module fiws_divider
  import fiws_pkg::*;
#(
  parameter int unsigned DividendW = 41,
  parameter int unsigned DivisorW  = 9
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic [DividendW-1:0] dividend_i,
  input  wire logic [DivisorW-1:0]  divisor_i,
  output      div_stat_t            stat_o,
  output      logic [DividendW-1:0] quotient_o
);

  localparam int unsigned CntW_ = $clog2(DividendW + 1);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [CntW_-1:0]     cnt_q, cnt_d;
  logic [DivisorW-1:0]  rem_q, rem_d;
  logic [DividendW-1:0] quo_q, quo_d;
  logic [DivisorW-1:0]  dvs_q, dvs_d;
  logic [DivisorW:0]    shifted;
  logic [DivisorW:0]    dvs_ext;
  logic [DivisorW:0]    diff;
  logic                 ge;

  assign shifted = {rem_q, quo_q[DividendW-1]};
  assign dvs_ext = {1'b0, dvs_q};
  assign ge      = shifted >= dvs_ext;
  assign diff    = shifted - dvs_ext;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i && !busy_q) begin
      busy_d = 1'b1;
      cnt_d  = CntW_'(DividendW);
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = ge ? diff[DivisorW-1:0] : shifted[DivisorW-1:0];
      quo_d = {quo_q[DividendW-2:0], ge};
      cnt_d = cnt_q - CntW_'(1);
      if (cnt_q == CntW_'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quotient_o  = quo_q;

endmodule
`default_nettype wire

### sim/frame_interval_window_stats_tb.sv
// Self-checking testbench for the frame interval window statistics block.
`timescale 1ns / 1ps
module frame_interval_window_stats_tb;
  import fiws_pkg::*;

  localparam int unsigned WinDepth    = 256;
  localparam int unsigned CycleLimit  = 1_000_000;
  localparam int unsigned DrainCycles = WinDepth + 100;
  localparam int unsigned HoldCycles  = 3000;

  typedef struct packed {
    logic [IvlW-1:0]     interval;
    logic [TsW-1:0]      elapsed;
    logic [IvlW-1:0]     average;
    logic [IvlW-1:0]     maximum;
    logic [CntW-1:0]     frames;
    logic [FillOutW-1:0] fill;
  } frame_stats_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic                opcode_i = OpFrame;
  logic [TsW-1:0]      timestamp_us_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [IvlW-1:0]     interval_us_o;
  logic [TsW-1:0]      elapsed_us_o;
  logic [IvlW-1:0]     window_average_us_o;
  logic [IvlW-1:0]     window_maximum_us_o;
  logic [CntW-1:0]     frame_count_o;
  logic [FillOutW-1:0] window_fill_o;

  frame_interval_window_stats #(
    .WINDOW_DEPTH(WinDepth)
  ) u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .opcode_i           (opcode_i),
    .timestamp_us_i     (timestamp_us_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .interval_us_o      (interval_us_o),
    .elapsed_us_o       (elapsed_us_o),
    .window_average_us_o(window_average_us_o),
    .window_maximum_us_o(window_maximum_us_o),
    .frame_count_o      (frame_count_o),
    .window_fill_o      (window_fill_o)
  );

  always #10 clk_i = ~clk_i;

  frame_stats_t   expected_stats_q[$];
  int unsigned    mismatch_count = 0;
  int unsigned    cycle_count = 0;
  int unsigned    idle_pct = 0;
  int unsigned    stall_pct = 0;
  logic           hold_active = 1'b0;
  logic [TsW-1:0] last_sent_ts = '0;

  logic [TsW-1:0]  win_start;
  logic [TsW-1:0]  win_last;
  logic [IvlW-1:0] win_ring[WinDepth];
  int unsigned     win_wpos;
  int unsigned     win_fill;
  logic [CntW-1:0] win_frames;
  bit              win_running = 1'b0;

  task automatic report_mismatch(string msg);
    mismatch_count++;
    $display("[%0d] mismatch: %s", cycle_count, msg);
  endtask

  task automatic predict_window_stats(logic op, logic [TsW-1:0] ts);
    frame_stats_t    stats;
    logic [TsW-1:0]  span;
    logic [63:0]     total;
    logic [IvlW-1:0] peak;
    stats = '0;
    if (op == OpRestart || !win_running) begin
      win_start   = ts;
      win_last    = ts;
      win_wpos    = 0;
      win_fill    = 0;
      win_frames  = '0;
      win_running = 1'b1;
    end else begin
      span = ts - win_last;
      stats.interval = (span > TsW'(32'hFFFF_FFFF)) ? '1 : span[IvlW-1:0];
      stats.elapsed = ts - win_start;
      win_last = ts;
      if (stats.interval != '0) begin
        win_ring[win_wpos] = stats.interval;
        win_wpos = (win_wpos + 1) % WinDepth;
        if (win_fill < WinDepth) win_fill++;
      end
      total = '0;
      peak = '0;
      for (int unsigned i = 0; i < win_fill; i++) begin
        total += win_ring[i];
        if (win_ring[i] > peak) peak = win_ring[i];
      end
      stats.average = (win_fill != 0) ? IvlW'(total / win_fill) : '0;
      stats.maximum = peak;
      win_frames = win_frames + 1'b1;
      stats.frames = win_frames;
      stats.fill = FillOutW'(win_fill);
    end
    expected_stats_q.push_back(stats);
  endtask

  // Drives one request, holds it until accepted and records its prediction.
  task automatic send_request(logic op, logic [TsW-1:0] ts);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      opcode_i <= 1'($urandom);
      timestamp_us_i <= {16'($urandom), 32'($urandom)};
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i <= op;
    timestamp_us_i <= ts;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_window_stats(op, ts);
    last_sent_ts = ts;
  endtask

  function automatic logic [TsW-1:0] next_frame_time(logic [TsW-1:0] prev);
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 6) return prev;
    if (pick < 10) return {16'($urandom), 32'($urandom)};
    if (pick < 14) return prev + {16'($urandom_range(1, 65535)), 32'($urandom)};
    if (pick < 24) return prev + TsW'(32'($urandom));
    return prev + TsW'($urandom_range(1, 40000));
  endfunction

  always @(posedge clk_i) begin
    out_stall_i <= hold_active || ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk_i) begin : check_results
    frame_stats_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_stats_q.size() == 0) begin
        report_mismatch($sformatf("result with nothing expected, interval 0x%0h",
                                  interval_us_o));
      end else begin
        want = expected_stats_q.pop_front();
        if (interval_us_o !== want.interval)
          report_mismatch($sformatf("interval_us 0x%0h, expected 0x%0h",
                                    interval_us_o, want.interval));
        if (elapsed_us_o !== want.elapsed)
          report_mismatch($sformatf("elapsed_us 0x%0h, expected 0x%0h",
                                    elapsed_us_o, want.elapsed));
        if (window_average_us_o !== want.average)
          report_mismatch($sformatf("window_average_us 0x%0h, expected 0x%0h",
                                    window_average_us_o, want.average));
        if (window_maximum_us_o !== want.maximum)
          report_mismatch($sformatf("window_maximum_us 0x%0h, expected 0x%0h",
                                    window_maximum_us_o, want.maximum));
        if (frame_count_o !== want.frames)
          report_mismatch($sformatf("frame_count %0d, expected %0d",
                                    frame_count_o, want.frames));
        if (window_fill_o !== want.fill)
          report_mismatch($sformatf("window_fill %0d, expected %0d",
                                    window_fill_o, want.fill));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic test_directed_cases();
    logic [TsW-1:0] t;
    idle_pct = 0;
    stall_pct = 0;
    send_request(OpFrame, '0);
    send_request(OpFrame, TsW'(100));
    send_request(OpFrame, TsW'(100));
    send_request(OpFrame, TsW'(300));
    send_request(OpRestart, 48'hFFFF_FFFF_FF00);
    send_request(OpFrame, '1);
    send_request(OpFrame, TsW'(16));
    t = TsW'(16) + 48'h1_0000_0000;
    send_request(OpFrame, t);
    t = t + 48'hFFFF_FFFF;
    send_request(OpFrame, t);
    t = t + 48'hFFFF_FFFF_FFFF;
    send_request(OpFrame, t);
    send_request(OpRestart, '0);
    send_request(OpRestart, 48'h5555_5555_5555);
    send_request(OpFrame, 48'hAAAA_AAAA_AAAA);
    send_request(OpFrame, 48'hAAAA_AAAA_AAAB);
    send_request(OpRestart, '1);
    send_request(OpFrame, '1);
    send_request(OpFrame, '0);
    send_request(OpFrame, TsW'(2));
  endtask

  // A long run without restart fills the window and wraps its write position.
  task automatic test_window_wraparound();
    idle_pct = 0;
    stall_pct = 0;
    send_request(OpRestart, {16'($urandom), 32'($urandom)});
    repeat (300) send_request(OpFrame, next_frame_time(last_sent_ts));
  endtask

  task automatic test_random_traffic(int unsigned idle, int unsigned stall, int unsigned count);
    logic op;
    idle_pct = idle;
    stall_pct = stall;
    repeat (count) begin
      op = ($urandom_range(0, 99) < 5) ? OpRestart : OpFrame;
      send_request(op, next_frame_time(last_sent_ts));
    end
  endtask

  // The receiver holds off long enough for the block to back up into its input.
  task automatic test_output_backpressure();
    idle_pct = 14;
    stall_pct = 14;
    fork
      begin
        hold_active <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        hold_active <= 1'b0;
      end
      begin
        repeat (8) send_request(OpFrame, next_frame_time(last_sent_ts));
      end
    join
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_cases();
    test_window_wraparound();
    test_random_traffic(62, 0, 45);
    test_random_traffic(0, 62, 45);
    test_random_traffic(14, 14, 45);
    test_output_backpressure();
    in_valid_i <= 1'b0;
    while (expected_stats_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
